FILE: design/lbpa_pkg.sv
// Shared types and codes for the leased buffer pool allocator.
// Holds the channel payload structs, operation and status codes, and the
// control struct between the sequencer and the scan unit. No dependencies.
package lbpa_pkg;

	// Operation codes carried in the input beat
	localparam logic [1:0] FUNC_ACQUIRE     = 2'd0;
	localparam logic [1:0] FUNC_RELEASE     = 2'd1;
	localparam logic [1:0] FUNC_RELEASE_ALL = 2'd2;
	localparam logic [1:0] FUNC_UNUSED      = 2'd3;

	// Result status codes
	localparam logic [2:0] STAT_GOT_FREE    = 3'd0;
	localparam logic [2:0] STAT_GOT_RECLAIM = 3'd1;
	localparam logic [2:0] STAT_GOT_PREEMPT = 3'd2;
	localparam logic [2:0] STAT_RELEASED    = 3'd3;
	localparam logic [2:0] STAT_NOT_FOUND   = 3'd4;
	localparam logic [2:0] STAT_ALL_RELEASED = 3'd5;

	// Freed-slot counters saturate at the top of the output field
	localparam int          CNT_W   = 5;
	localparam logic [4:0]  CNT_MAX = 5'd31;

	localparam logic [15:0] LEASE_TIMEOUT_RESET = 16'd1200;
	localparam logic [31:0] ID_MAX              = 32'hFFFF_FFFF;
	localparam logic [31:0] ID_FIRST            = 32'd1;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] now_time;
		logic [31:0] release_id;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  slot_num;
		logic [31:0] granted_frame_id;
		logic [4:0]  freed_count;
	} out_item_t;

	// One slot entry held in the lease memory
	typedef struct packed {
		logic [31:0] owner;
		logic [31:0] lease_start;
	} slot_entry_t;

	// Sequencer to scan unit control
	typedef struct packed {
		logic clear;  // reset accumulators before a new scan
		logic vld;    // an entry is presented this cycle
		logic busy;   // busy bit of the presented entry
	} scan_ctl_t;

endpackage

FILE: design/lbpa_slot_mem.sv
// Lease memory: owner id and lease start time per slot.
// One write port, one registered read port. Uses lbpa_pkg::slot_entry_t.
module lbpa_slot_mem #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [IDX_W-1:0]     waddr,
	input  lbpa_pkg::slot_entry_t wdata,
	input  logic                 re,
	input  logic [IDX_W-1:0]     raddr,
	output lbpa_pkg::slot_entry_t rdata
);

	lbpa_pkg::slot_entry_t mem [DEPTH];
	lbpa_pkg::slot_entry_t rdata_q;

	// Write on grant, read during scan
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/lbpa_scan_unit.sv
// Shared scan unit: one age subtractor plus compares, applied to one slot
// per cycle, with accumulators for the free, stale, oldest and match search and busy count.
// Depends on lbpa_pkg.
module lbpa_scan_unit #(
	parameter int SLOTS = 16,
	parameter int IDX_W = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lbpa_pkg::scan_ctl_t   ctl,
	input  logic [IDX_W-1:0]      idx,
	input  lbpa_pkg::slot_entry_t entry,
	input  logic [31:0]           now_time,
	input  logic [31:0]           release_id,
	input  logic [15:0]           lease_timeout,
	output logic                  free_found,
	output logic [IDX_W-1:0]      free_idx,
	output logic [4:0]            stale_cnt,
	output logic [IDX_W-1:0]      stale_first,
	output logic [SLOTS-1:0]      stale_mask,
	output logic [IDX_W-1:0]      best_idx,
	output logic                  match_found,
	output logic [IDX_W-1:0]      match_idx,
	output logic [4:0]            busy_cnt
);

	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [4:0]        stale_cnt_q;
	logic [IDX_W-1:0]  stale_first_q;
	logic [SLOTS-1:0]  stale_mask_q;
	logic              best_set_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [31:0]       best_age_q;
	logic              match_found_q;
	logic [IDX_W-1:0]  match_idx_q;
	logic [4:0]        busy_cnt_q;

	logic [31:0] age;
	logic        is_stale;
	logic        is_older;
	logic        is_match;

	// Shared arithmetic: age modulo 2^32 and the three compares
	always_comb begin
		age      = now_time - entry.lease_start;
		is_stale = ctl.busy && (age > {16'd0, lease_timeout});
		is_older = !best_set_q || (age > best_age_q);
		is_match = ctl.busy && (entry.owner == release_id);
	end

	// Accumulate search results one slot at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			stale_cnt_q   <= '0;
			stale_first_q <= '0;
			stale_mask_q  <= '0;
			best_set_q    <= 1'b0;
			best_idx_q    <= '0;
			best_age_q    <= '0;
			match_found_q <= 1'b0;
			match_idx_q   <= '0;
			busy_cnt_q    <= '0;
		end else if (ctl.clear) begin
			free_found_q  <= 1'b0;
			stale_cnt_q   <= '0;
			stale_mask_q  <= '0;
			best_set_q    <= 1'b0;
			match_found_q <= 1'b0;
			busy_cnt_q    <= '0;
		end else if (ctl.vld) begin
			if (!ctl.busy && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx;
			end
			if (is_stale) begin
				stale_mask_q[idx] <= 1'b1;
				if (stale_cnt_q == '0) begin
					stale_first_q <= idx;
				end
				if (stale_cnt_q != lbpa_pkg::CNT_MAX) begin
					stale_cnt_q <= stale_cnt_q + 5'd1;
				end
			end
			if (is_older) begin
				best_set_q <= 1'b1;
				best_idx_q <= idx;
				best_age_q <= age;
			end
			if (is_match && !match_found_q) begin
				match_found_q <= 1'b1;
				match_idx_q   <= idx;
			end
			if (ctl.busy && busy_cnt_q != lbpa_pkg::CNT_MAX) begin
				busy_cnt_q <= busy_cnt_q + 5'd1;
			end
		end
	end

	assign free_found  = free_found_q;
	assign free_idx    = free_idx_q;
	assign stale_cnt   = stale_cnt_q;
	assign stale_first = stale_first_q;
	assign stale_mask  = stale_mask_q;
	assign best_idx    = best_idx_q;
	assign match_found = match_found_q;
	assign match_idx   = match_idx_q;
	assign busy_cnt    = busy_cnt_q;

endmodule

FILE: design/leased_buffer_pool_allocator.sv
// Top level of the leased buffer pool allocator: sequencer, busy bits,
// id counter, config register and output register. Depends on lbpa_pkg,
// lbpa_slot_mem and lbpa_scan_unit.
//
//  channel | signals                      | direction | beat taken when
//  --------+------------------------------+-----------+-------------------------
//  in      | in_valid in_stall in_data    | to block  | in_valid && !in_stall
//  out     | out_valid out_stall out_data | from block| out_valid && !out_stall
//  cfg     | cfg_valid cfg_ready cfg_data | to block  | cfg_valid && cfg_ready
//
// Each operation runs one scan of the lease memory through its single read
// port, one slot per cycle, and then a commit cycle. Operation code 3 is
// taken and gives no result.
// Reset clears all busy bits at once; the lease memory needs no clearing.
// A held result stalls only the commit cycle of the following operation.
module leased_buffer_pool_allocator #(
	parameter int POOL_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lbpa_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output lbpa_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);

	localparam int               IDX_W    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t                state_q;
	lbpa_pkg::in_item_t    op_q;
	logic [15:0]           lease_timeout_q;
	logic [POOL_SLOTS-1:0] busy_q;
	logic [31:0]           next_id_q;
	logic                  issue_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic                  chk_vld_s1;
	logic [IDX_W-1:0]      chk_idx_s1;
	logic                  out_valid_q;
	lbpa_pkg::out_item_t   out_q;

	logic                  in_take;
	logic                  fin_go;
	lbpa_pkg::scan_ctl_t   ctl;
	lbpa_pkg::slot_entry_t rd_entry;
	lbpa_pkg::slot_entry_t wr_entry;

	logic                  free_found;
	logic [IDX_W-1:0]      free_idx;
	logic [4:0]            stale_cnt;
	logic [IDX_W-1:0]      stale_first;
	logic [POOL_SLOTS-1:0] stale_mask;
	logic [IDX_W-1:0]      best_idx;
	logic                  match_found;
	logic [IDX_W-1:0]      match_idx;
	logic [4:0]            busy_cnt;

	logic                  grant_en;
	logic [IDX_W-1:0]      g_idx;
	logic [IDX_W-1:0]      slot_sel;
	logic [IDX_W+3:0]      slot_wide;
	logic [POOL_SLOTS-1:0] busy_n;
	lbpa_pkg::out_item_t   out_n;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign fin_go    = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;

	// Hold the lease timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lease_timeout_q <= lbpa_pkg::LEASE_TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			lease_timeout_q <= cfg_data;
		end
	end

	// Sequencer: accept, scan every slot, commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			issue_q    <= 1'b0;
			rd_idx_q   <= '0;
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					chk_vld_s1 <= 1'b0;
					if (in_take && in_data.func != lbpa_pkg::FUNC_UNUSED) begin
						state_q  <= ST_SCAN;
						issue_q  <= 1'b1;
						rd_idx_q <= '0;
					end
				end
				ST_SCAN: begin
					chk_vld_s1 <= issue_q;
					chk_idx_s1 <= rd_idx_q;
					if (issue_q) begin
						if (rd_idx_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					if (chk_vld_s1 && chk_idx_s1 == LAST_IDX) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					chk_vld_s1 <= 1'b0;
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the operation beat
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q <= in_data;
		end
	end

	// Drive the scan unit
	always_comb begin
		ctl.clear = in_take;
		ctl.vld   = (state_q == ST_SCAN) && chk_vld_s1;
		ctl.busy  = busy_q[chk_idx_s1];
	end

	lbpa_slot_mem #(
		.DEPTH (POOL_SLOTS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (fin_go && grant_en),
		.waddr (g_idx),
		.wdata (wr_entry),
		.re    ((state_q == ST_SCAN) && issue_q),
		.raddr (rd_idx_q),
		.rdata (rd_entry)
	);

	lbpa_scan_unit #(
		.SLOTS (POOL_SLOTS),
		.IDX_W (IDX_W)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.idx           (chk_idx_s1),
		.entry         (rd_entry),
		.now_time      (op_q.now_time),
		.release_id    (op_q.release_id),
		.lease_timeout (lease_timeout_q),
		.free_found    (free_found),
		.free_idx      (free_idx),
		.stale_cnt     (stale_cnt),
		.stale_first   (stale_first),
		.stale_mask    (stale_mask),
		.best_idx      (best_idx),
		.match_found   (match_found),
		.match_idx     (match_idx),
		.busy_cnt      (busy_cnt)
	);

	// Decide the commit: grant slot, busy update and result
	always_comb begin
		grant_en = 1'b0;
		g_idx    = '0;
		slot_sel = '0;
		busy_n   = busy_q;
		out_n    = '0;
		unique case (op_q.func)
			lbpa_pkg::FUNC_ACQUIRE: begin
				grant_en = 1'b1;
				if (free_found) begin
					g_idx        = free_idx;
					out_n.status = lbpa_pkg::STAT_GOT_FREE;
				end else if (stale_cnt != '0) begin
					g_idx             = stale_first;
					busy_n            = busy_q & ~stale_mask;
					out_n.status      = lbpa_pkg::STAT_GOT_RECLAIM;
					out_n.freed_count = stale_cnt;
				end else begin
					g_idx        = best_idx;
					out_n.status = lbpa_pkg::STAT_GOT_PREEMPT;
				end
				busy_n[g_idx]          = 1'b1;
				slot_sel               = g_idx;
				out_n.granted_frame_id = next_id_q;
			end
			lbpa_pkg::FUNC_RELEASE: begin
				if (match_found) begin
					busy_n[match_idx] = 1'b0;
					slot_sel          = match_idx;
					out_n.status      = lbpa_pkg::STAT_RELEASED;
				end else begin
					out_n.status = lbpa_pkg::STAT_NOT_FOUND;
				end
			end
			lbpa_pkg::FUNC_RELEASE_ALL: begin
				busy_n            = '0;
				out_n.status      = lbpa_pkg::STAT_ALL_RELEASED;
				out_n.freed_count = busy_cnt;
			end
			default: begin
				busy_n = busy_q;
			end
		endcase
		slot_wide      = {4'b0000, slot_sel};
		out_n.slot_num = slot_wide[3:0];
	end

	assign wr_entry.owner       = next_id_q;
	assign wr_entry.lease_start = op_q.now_time;

	// Commit busy bits and advance the frame id
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= '0;
			next_id_q <= lbpa_pkg::ID_FIRST;
		end else if (fin_go) begin
			busy_q <= busy_n;
			if (grant_en) begin
				next_id_q <= (next_id_q == lbpa_pkg::ID_MAX) ? lbpa_pkg::ID_FIRST
				                                             : next_id_q + 32'd1;
			end
		end
	end

	// Output register: load on commit, drop on a taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_q <= out_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A new result appears only out of the commit cycle
	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside commit");

	// Handed-out frame ids are never zero
	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != 32'd0)
		else $error("frame id counter reached zero");

	// Release results carry no granted id
	a_release_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.status == lbpa_pkg::STAT_RELEASED ||
		               out_data.status == lbpa_pkg::STAT_NOT_FOUND ||
		               out_data.status == lbpa_pkg::STAT_ALL_RELEASED))
		|-> out_data.granted_frame_id == 32'd0)
		else $error("release result carries a frame id");

	// A reclaim always frees at least one slot
	a_reclaim_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == lbpa_pkg::STAT_GOT_RECLAIM)
		|-> out_data.freed_count != 5'd0)
		else $error("reclaim freed no slot");

endmodule
